// File: hw/rtl/acst_pkg.sv
// Shared types and constants for the box contact side tracker.
package acst_pkg;

  localparam int FLD_COORD_W  = 24;
  localparam int FLD_SIZE_W   = 16;
  localparam int GHOST_ITEM_W = 10;
  localparam int COORD_EXT_W  = 32;
  localparam int CLS_DEPTH    = 4;
  localparam int RES_DEPTH    = 2;

  typedef struct packed {
    logic signed [FLD_COORD_W-1:0] self_x;
    logic signed [FLD_COORD_W-1:0] self_y;
    logic [FLD_SIZE_W-1:0]         self_width;
    logic [FLD_SIZE_W-1:0]         self_height;
    logic                          self_ghost;
    logic                          other_present;
    logic signed [FLD_COORD_W-1:0] other_x;
    logic signed [FLD_COORD_W-1:0] other_y;
    logic [FLD_SIZE_W-1:0]         other_width;
    logic [FLD_SIZE_W-1:0]         other_height;
    logic                          other_ghost;
    logic                          frame_end;
  } acst_in_t;

  typedef struct packed {
    logic                    grounded;
    logic                    top_blocked;
    logic                    left_blocked;
    logic                    right_blocked;
    logic                    ghost_hit;
    logic [GHOST_ITEM_W-1:0] ghost_item;
    logic                    ghost_enter;
    logic                    ghost_stay;
    logic                    ghost_exit;
  } acst_out_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    logic grounded;
    logic top;
    logic left;
    logic right;
    logic ghost;
    logic frame_end;
  } acst_cls_t;

endpackage

// File: hw/rtl/acst_queue.sv
// Small register queue with push/full and pop/empty sides.
module acst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hw/rtl/acst_front.sv
// Front end: edge build, overlap test and smallest-gap classification.
module acst_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acst_pkg::acst_in_t  in_item,
  output logic                cls_valid,
  output acst_pkg::acst_cls_t cls_item,
  input  logic                cls_full
);
  import acst_pkg::*;

  // doubled edges need room for 2*center plus a full size
  localparam int EW = ((COORD_BITS > FLD_SIZE_W) ? COORD_BITS : FLD_SIZE_W) + 2;
  localparam int DW = EW + 1;

  function automatic logic signed [EW-1:0] dbl(input logic [FLD_COORD_W-1:0] f);
    logic [COORD_EXT_W-1:0]       e;
    logic signed [COORD_BITS-1:0] c;
    e = COORD_EXT_W'(f);
    c = e[COORD_BITS-1:0];
    return EW'(c) <<< 1;
  endfunction

  function automatic logic signed [EW-1:0] sz(input logic [FLD_SIZE_W-1:0] s);
    return signed'(EW'(s));
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  logic stall;

  // stage 1: edges
  logic                 s1_valid_r;
  logic signed [EW-1:0] l0_r, r0_r, b0_r, t0_r, l1_r, r1_r, b1_r, t1_r;
  logic                 s1_present_r, s1_solid_r, s1_fend_r;

  // stage 2: overlap and signed gaps
  logic                 s2_valid_r;
  logic signed [DW-1:0] dgb_r, dgt_r, dgl_r, dgr_r;
  logic                 s2_solid_r, s2_ghost_r, s2_fend_r;
  logic                 hit;

  // stage 3: gap magnitudes
  logic                 s3_valid_r;
  logic [DW-1:0]        gb_r, gt_r, gl_r, gr_r;
  logic                 s3_solid_r, s3_ghost_r, s3_fend_r;

  assign stall    = s3_valid_r && cls_full;
  assign in_stall = stall;

  assign hit = !(r0_r < l1_r || l0_r > r1_r || b0_r > t1_r || t0_r < b1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (!stall) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      l0_r         <= dbl(in_item.self_x) - sz(in_item.self_width);
      r0_r         <= dbl(in_item.self_x) + sz(in_item.self_width);
      b0_r         <= dbl(in_item.self_y) - sz(in_item.self_height);
      t0_r         <= dbl(in_item.self_y) + sz(in_item.self_height);
      l1_r         <= dbl(in_item.other_x) - sz(in_item.other_width);
      r1_r         <= dbl(in_item.other_x) + sz(in_item.other_width);
      b1_r         <= dbl(in_item.other_y) - sz(in_item.other_height);
      t1_r         <= dbl(in_item.other_y) + sz(in_item.other_height);
      s1_present_r <= in_item.other_present;
      s1_solid_r   <= !in_item.self_ghost && !in_item.other_ghost;
      s1_fend_r    <= in_item.frame_end;

      dgb_r      <= DW'(b0_r) - DW'(t1_r);
      dgt_r      <= DW'(t0_r) - DW'(b1_r);
      dgl_r      <= DW'(l0_r) - DW'(r1_r);
      dgr_r      <= DW'(r0_r) - DW'(l1_r);
      s2_solid_r <= s1_present_r && hit && s1_solid_r;
      s2_ghost_r <= s1_present_r && hit && !s1_solid_r;
      s2_fend_r  <= s1_fend_r;

      gb_r       <= mag(dgb_r);
      gt_r       <= mag(dgt_r);
      gl_r       <= mag(dgl_r);
      gr_r       <= mag(dgr_r);
      s3_solid_r <= s2_solid_r;
      s3_ghost_r <= s2_ghost_r;
      s3_fend_r  <= s2_fend_r;
    end
  end

  // strictly smallest gap wins; any tie for smallest sets nothing
  assign cls_valid          = s3_valid_r;
  assign cls_item.grounded  = s3_solid_r && gb_r < gt_r && gb_r < gl_r && gb_r < gr_r;
  assign cls_item.top       = s3_solid_r && gt_r < gb_r && gt_r < gl_r && gt_r < gr_r;
  assign cls_item.left      = s3_solid_r && gl_r < gt_r && gl_r < gb_r && gl_r < gr_r;
  assign cls_item.right     = s3_solid_r && gr_r < gt_r && gr_r < gb_r && gr_r < gl_r;
  assign cls_item.ghost     = s3_ghost_r;
  assign cls_item.frame_end = s3_fend_r;

endmodule

// File: hw/rtl/acst_back.sv
// Back end: per-frame accumulation, ghost tracking and result build.
module acst_back #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cls_empty,
  input  acst_pkg::acst_cls_t cls_item,
  output logic                cls_pop,
  output logic                res_push,
  output acst_pkg::acst_out_t res_item,
  input  logic                res_full
);
  import acst_pkg::*;

  localparam int IDX_MAX = (1 << GHOST_ITEM_W) - 1;
  localparam int CNT_MAX = (MAX_ITEMS - 1 < IDX_MAX) ? MAX_ITEMS - 1 : IDX_MAX;
  localparam int CW      = $clog2(CNT_MAX + 1);

  logic          go, fend;
  logic          grounded_r, top_r, left_r, right_r, seen_r, stay_prev_r;
  logic          grounded_nxt, top_nxt, left_nxt, right_nxt, seen_nxt, stay_prev_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          hit_all, ground_all, top_all, left_all, right_all;
  logic [CW-1:0] first_all;

  // a frame end request waits until the result queue has room
  assign go       = !cls_empty && (!cls_item.frame_end || !res_full);
  assign fend     = go && cls_item.frame_end;
  assign cls_pop  = go;
  assign res_push = fend;

  always_comb begin
    ground_all = grounded_r || cls_item.grounded;
    top_all    = top_r || cls_item.top;
    left_all   = left_r || cls_item.left;
    right_all  = right_r || cls_item.right;
    hit_all    = seen_r || cls_item.ghost;
    first_all  = seen_r ? first_r : (cls_item.ghost ? count_r : '0);
  end

  always_comb begin
    res_item.grounded      = ground_all;
    res_item.top_blocked   = top_all;
    res_item.left_blocked  = left_all;
    res_item.right_blocked = right_all;
    res_item.ghost_hit     = hit_all;
    res_item.ghost_item    = GHOST_ITEM_W'(first_all);
    res_item.ghost_enter   = hit_all && !stay_prev_r;
    res_item.ghost_stay    = hit_all;
    res_item.ghost_exit    = !hit_all && stay_prev_r;
  end

  always_comb begin
    grounded_nxt  = grounded_r;
    top_nxt       = top_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    seen_nxt      = seen_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    stay_prev_nxt = stay_prev_r;
    if (fend) begin
      grounded_nxt  = 1'b0;
      top_nxt       = 1'b0;
      left_nxt      = 1'b0;
      right_nxt     = 1'b0;
      seen_nxt      = 1'b0;
      first_nxt     = '0;
      count_nxt     = '0;
      stay_prev_nxt = hit_all;
    end else if (go) begin
      grounded_nxt = ground_all;
      top_nxt      = top_all;
      left_nxt     = left_all;
      right_nxt    = right_all;
      seen_nxt     = hit_all;
      first_nxt    = first_all;
      if (count_r < CW'(CNT_MAX)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grounded_r  <= 1'b0;
      top_r       <= 1'b0;
      left_r      <= 1'b0;
      right_r     <= 1'b0;
      seen_r      <= 1'b0;
      first_r     <= '0;
      count_r     <= '0;
      stay_prev_r <= 1'b0;
    end else begin
      grounded_r  <= grounded_nxt;
      top_r       <= top_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      seen_r      <= seen_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      stay_prev_r <= stay_prev_nxt;
    end
  end

endmodule

// File: hw/rtl/aabb_contact_side_tracker.sv
// Top level of the box contact side tracker.
//
// One box (self) is tested against a stream of other boxes, one request per
// other box; the request with frame_end set closes the frame and produces one
// result with the four side flags and the ghost enter/stay/exit status.
// Requests without frame_end produce no result.
// Input side: drive in_data and push; the request is taken on a clock edge
// with push high and full low. Result side: a result sits on out_data while
// empty is low and is taken on an edge with pop high.
// The result of a frame end request shows on out_data once it has passed
// the three front stages, the front-to-back queue and the back step into the
// result queue, if the result queue has room.
// Throughput: one request per cycle while full is low, set by the
// three-stage edge/gap/magnitude pipeline and the one-step back end.
// A four-entry queue between front and back and a two-entry result queue let
// results wait while requests keep flowing; full rises only once both fill.
// Reset (rst_n low, synchronous) empties both queues and the pipeline and
// clears all per-frame state and the previous ghost status.
module aabb_contact_side_tracker #(
  parameter int MAX_ITEMS  = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  acst_pkg::acst_in_t  in_data,
  output logic                empty,
  input  logic                pop,
  output acst_pkg::acst_out_t out_data
);
  import acst_pkg::*;

  localparam int CLS_W = $bits(acst_cls_t);
  localparam int RES_W = $bits(acst_out_t);

  logic             cls_valid, cls_full, cls_empty, cls_pop;
  acst_cls_t        cls_in, cls_out;
  logic [CLS_W-1:0] cls_dout;
  logic             res_push, res_full;
  acst_out_t        res_in;
  logic [RES_W-1:0] res_dout;

  acst_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push),
    .in_stall (full),
    .in_item  (in_data),
    .cls_valid(cls_valid),
    .cls_item (cls_in),
    .cls_full (cls_full)
  );

  acst_queue #(
    .WIDTH(CLS_W),
    .DEPTH(CLS_DEPTH)
  ) u_cls_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cls_valid),
    .full (cls_full),
    .din  (cls_in),
    .pop  (cls_pop),
    .empty(cls_empty),
    .dout (cls_dout)
  );

  assign cls_out = acst_cls_t'(cls_dout);

  acst_back #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cls_empty(cls_empty),
    .cls_item (cls_out),
    .cls_pop  (cls_pop),
    .res_push (res_push),
    .res_item (res_in),
    .res_full (res_full)
  );

  acst_queue #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .full (res_full),
    .din  (res_in),
    .pop  (pop),
    .empty(empty),
    .dout (res_dout)
  );

  assign out_data = acst_out_t'(res_dout);

endmodule

// File: hw/rtl/acst_checker.sv
// Port-level checks for the box contact side tracker, bound to the top level.
module acst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input acst_pkg::acst_out_t out_data
);
  import acst_pkg::*;

  // ghost status of the last result taken
  logic prev_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_hit_r <= 1'b0;
    end else if (pop && !empty) begin
      prev_hit_r <= out_data.ghost_hit;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  a_enter_exit: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.ghost_enter == (out_data.ghost_hit && !prev_hit_r))
            && (out_data.ghost_exit == (!out_data.ghost_hit && prev_hit_r)))
    else $error("ghost enter/exit disagrees with previous result");

  a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.ghost_hit) |-> (out_data.ghost_item == '0))
    else $error("ghost index set without ghost overlap");

endmodule

bind aabb_contact_side_tracker acst_checker u_acst_checker (.*);

// File: tb/sv/contact_result_checker.sv
// Checker for the box contact side tracker: predicts frame results and compares them.
`timescale 1ns / 1ps

module contact_result_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic                full,
  input  acst_pkg::acst_in_t  req,
  input  logic                empty,
  input  logic                pop,
  input  acst_pkg::acst_out_t res,
  output int                  fail_cnt,
  output int                  pending
);
  import acst_pkg::*;

  // item index saturates at 1023, the design's min(MAX_ITEMS-1, 1023) for MAX_ITEMS >= 1024
  localparam int IDX_MAX = 1023;

  acst_out_t flags_due[$];
  acst_out_t want;

  logic gnd_acc, top_acc, lft_acc, rgt_acc;
  logic ghost_seen, ghost_prev;
  logic [GHOST_ITEM_W-1:0] ghost_first, item_idx;

  initial begin
    fail_cnt = 0;
    pending  = 0;
  end

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic clear_frame();
    gnd_acc     = 1'b0;
    top_acc     = 1'b0;
    lft_acc     = 1'b0;
    rgt_acc     = 1'b0;
    ghost_seen  = 1'b0;
    ghost_first = '0;
    item_idx    = '0;
  endtask

  // Fold one request into the frame state; a frame end queues the result.
  task automatic track_req(input acst_in_t r);
    longint l0, r0, b0, t0, l1, r1, b1, t1;
    longint gb, gt, gl, gr;
    acst_out_t o;
    if (r.other_present) begin
      // doubled edges: 2*center -/+ size
      l0 = 2 * longint'($signed(r.self_x)) - longint'(r.self_width);
      r0 = 2 * longint'($signed(r.self_x)) + longint'(r.self_width);
      b0 = 2 * longint'($signed(r.self_y)) - longint'(r.self_height);
      t0 = 2 * longint'($signed(r.self_y)) + longint'(r.self_height);
      l1 = 2 * longint'($signed(r.other_x)) - longint'(r.other_width);
      r1 = 2 * longint'($signed(r.other_x)) + longint'(r.other_width);
      b1 = 2 * longint'($signed(r.other_y)) - longint'(r.other_height);
      t1 = 2 * longint'($signed(r.other_y)) + longint'(r.other_height);
      if (!(r0 < l1 || l0 > r1 || b0 > t1 || t0 < b1)) begin
        if (!r.self_ghost && !r.other_ghost) begin
          gb = mag(b0 - t1);
          gt = mag(t0 - b1);
          gl = mag(l0 - r1);
          gr = mag(r0 - l1);
          // only a strictly smallest gap picks a side
          if (gb < gt && gb < gl && gb < gr) gnd_acc = 1'b1;
          else if (gt < gb && gt < gl && gt < gr) top_acc = 1'b1;
          else if (gl < gt && gl < gb && gl < gr) lft_acc = 1'b1;
          else if (gr < gt && gr < gb && gr < gl) rgt_acc = 1'b1;
        end else if (!ghost_seen) begin
          ghost_seen  = 1'b1;
          ghost_first = item_idx;
        end
      end
    end
    if (item_idx < IDX_MAX) item_idx = item_idx + 1'b1;
    if (r.frame_end) begin
      o.grounded      = gnd_acc;
      o.top_blocked   = top_acc;
      o.left_blocked  = lft_acc;
      o.right_blocked = rgt_acc;
      o.ghost_hit     = ghost_seen;
      o.ghost_item    = ghost_seen ? ghost_first : '0;
      o.ghost_enter   = ghost_seen && !ghost_prev;
      o.ghost_stay    = ghost_seen;
      o.ghost_exit    = !ghost_seen && ghost_prev;
      flags_due.push_back(o);
      ghost_prev = ghost_seen;
      clear_frame();
    end
  endtask

  task automatic check_fld(input string name, input logic [GHOST_ITEM_W-1:0] exp_v,
                           input logic [GHOST_ITEM_W-1:0] got_v);
    if (got_v !== exp_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      ghost_prev = 1'b0;
      flags_due.delete();
    end else begin
      if (pop && !empty) begin
        if (flags_due.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: expected none, got %p", $time, res);
        end else begin
          want = flags_due.pop_front();
          check_fld("grounded", want.grounded, res.grounded);
          check_fld("top_blocked", want.top_blocked, res.top_blocked);
          check_fld("left_blocked", want.left_blocked, res.left_blocked);
          check_fld("right_blocked", want.right_blocked, res.right_blocked);
          check_fld("ghost_hit", want.ghost_hit, res.ghost_hit);
          check_fld("ghost_item", want.ghost_item, res.ghost_item);
          check_fld("ghost_enter", want.ghost_enter, res.ghost_enter);
          check_fld("ghost_stay", want.ghost_stay, res.ghost_stay);
          check_fld("ghost_exit", want.ghost_exit, res.ghost_exit);
        end
      end
      if (push && !full) track_req(req);
    end
    pending = flags_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the box contact side tracker: stimulus, idling phases and verdict.
`timescale 1ns / 1ps

module tb;
  import acst_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  acst_in_t  in_data;
  logic      empty;
  logic      pop = 1'b0;
  acst_out_t out_data;

  int fail_cnt;
  int pending;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  always #2 clk = ~clk;

  aabb_contact_side_tracker #(
    .MAX_ITEMS  (1024),
    .COORD_BITS (24)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  contact_result_checker i_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .req      (in_data),
    .empty    (empty),
    .pop      (pop),
    .res      (out_data),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

  initial begin
    #2_000_000;
    $display("** aabb_contact_side_tracker: FAILED **");
    $finish;
  end

  function automatic acst_in_t mk(input int sx, input int sy, input int sw, input int sh,
                                  input bit sg, input bit op, input int ox, input int oy,
                                  input int ow, input int oh, input bit og, input bit fe);
    acst_in_t r;
    r.self_x        = FLD_COORD_W'(sx);
    r.self_y        = FLD_COORD_W'(sy);
    r.self_width    = FLD_SIZE_W'(sw);
    r.self_height   = FLD_SIZE_W'(sh);
    r.self_ghost    = sg;
    r.other_present = op;
    r.other_x       = FLD_COORD_W'(ox);
    r.other_y       = FLD_COORD_W'(oy);
    r.other_width   = FLD_SIZE_W'(ow);
    r.other_height  = FLD_SIZE_W'(oh);
    r.other_ghost   = og;
    r.frame_end     = fe;
    return r;
  endfunction

  function automatic logic [FLD_COORD_W-1:0] rand_coord();
    int v;
    if ($urandom_range(7) == 0) return FLD_COORD_W'($urandom);
    v = int'($urandom_range(1 << 21)) - (1 << 20);
    return FLD_COORD_W'(v);
  endfunction

  function automatic logic [FLD_SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return FLD_SIZE_W'($urandom_range(1024));
      default: return FLD_SIZE_W'($urandom);
    endcase
  endfunction

  function automatic acst_in_t rand_self();
    acst_in_t r;
    r             = '0;
    r.self_x      = rand_coord();
    r.self_y      = rand_coord();
    r.self_width  = rand_size();
    r.self_height = rand_size();
    r.self_ghost  = ($urandom_range(5) == 0);
    return r;
  endfunction

  // Mostly boxes near self (overlapping, touching or just apart), some ties and some noise.
  function automatic acst_in_t rand_req(input acst_in_t base, input bit is_last);
    acst_in_t r;
    logic [191:0] noise;
    int kind, reach_x, reach_y, dx, dy;
    r               = base;
    r.other_width   = rand_size();
    r.other_height  = rand_size();
    r.other_ghost   = ($urandom_range(4) == 0);
    r.other_present = ($urandom_range(9) != 0);
    kind = $urandom_range(99);
    if (kind < 15) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(acst_in_t)-1:0];
    end else if (kind < 25) begin
      r.other_x      = r.self_x;
      r.other_y      = r.self_y;
      r.other_width  = r.self_width;
      r.other_height = r.self_height;
    end else begin
      reach_x = (int'(r.self_width) + int'(r.other_width)) / 2;
      reach_y = (int'(r.self_height) + int'(r.other_height)) / 2;
      dx = int'($urandom_range(2 * reach_x + 8)) - reach_x - 4;
      dy = int'($urandom_range(2 * reach_y + 8)) - reach_y - 4;
      // snap one axis to touching edges now and then
      case ($urandom_range(5))
        0:       dx = $urandom_range(1) ? reach_x : -reach_x;
        1:       dy = $urandom_range(1) ? reach_y : -reach_y;
        default: ;
      endcase
      r.other_x = FLD_COORD_W'(int'($signed(r.self_x)) + dx);
      r.other_y = FLD_COORD_W'(int'($signed(r.self_y)) + dy);
    end
    r.frame_end = is_last;
    return r;
  endfunction

  // Called and returns at a falling edge; push stays high until the next call.
  task automatic send_req(input acst_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    in_data <= r;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_frame(input int n);
    acst_in_t base;
    base = rand_self();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) base = rand_self();
      send_req(rand_req(base, i == n - 1));
    end
  endtask

  initial begin
    int sent, n, pick;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: each side touching, ties, ghosts, absent items, extremes
    send_req(mk(0, 0, 512, 512, 0, 1, 0, -512, 512, 512, 0, 1));
    send_req(mk(0, 0, 512, 512, 0, 1, 0, 512, 512, 512, 0, 1));
    send_req(mk(0, 0, 512, 512, 0, 1, -512, 0, 512, 512, 0, 0));
    send_req(mk(0, 0, 512, 512, 0, 1, 512, 0, 512, 512, 0, 1));
    send_req(mk(0, 0, 512, 512, 0, 1, 0, 0, 512, 512, 0, 1));
    send_req(mk(0, 0, 512, 512, 1, 1, 0, 0, 512, 512, 0, 0));
    send_req(mk(0, 0, 512, 512, 0, 0, 0, 0, 512, 512, 0, 0));
    send_req(mk(0, 0, 512, 512, 0, 1, 100, 0, 512, 512, 1, 1));
    send_req(mk(0, 0, 512, 512, 0, 0, 0, 0, 512, 512, 0, 0));
    send_req(mk(0, 0, 512, 512, 0, 1, 0, 0, 512, 512, 1, 1));
    send_req(mk(0, 0, 512, 512, 0, 0, 0, 0, 512, 512, 1, 1));
    send_req(mk(0, 0, 512, 512, 0, 1, 513, 0, 512, 512, 0, 1));
    send_req(mk(8388607, -8388608, 65535, 65535, 0, 1,
                8388607, -8388608, 0, 0, 0, 0));
    send_req(mk(-8388608, 8388607, 0, 0, 0, 1, 8388607, -8388608, 65535, 65535, 0, 1));
    send_req(mk(-1, -1, 0, 0, 0, 1, -1, -1, 0, 0, 0, 1));
    send_req(mk(0, 0, 65535, 65535, 0, 1, 0, -40000, 65535, 65535, 0, 0));
    send_req(mk(0, 0, 65535, 65535, 0, 1, 40000, 0, 65535, 65535, 0, 1));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 53; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 53; end
        default: begin send_idle_pct = 26; pop_stall_pct = 26; end
      endcase
      sent = 0;
      if (ph == 1) begin
        // long frame: first ghost overlap past the index saturation point
        for (int i = 0; i < 1030; i++)
          send_req(mk(0, 0, 512, 512, 0, i == 1026, 0, 0, 512, 512, 1, i == 1029));
        sent = 1030;
      end
      while (sent < 250) begin
        pick = $urandom_range(99);
        if (pick < 70) n = $urandom_range(1, 6);
        else if (pick < 95) n = $urandom_range(7, 40);
        else n = $urandom_range(41, 200);
        run_frame(n);
        sent += n;
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("** aabb_contact_side_tracker: PASSED **");
    end else begin
      $display("** aabb_contact_side_tracker: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/acst_pkg.sv
hw/rtl/acst_queue.sv
hw/rtl/acst_front.sv
hw/rtl/acst_back.sv
hw/rtl/aabb_contact_side_tracker.sv
hw/rtl/acst_checker.sv
tb/sv/contact_result_checker.sv
tb/sv/tb.sv
